@@ design/khddm_pkg.sv @@
// Shared types, codes and constants for the key-hold differential drive mixer.
// Used by every module of the block but the checker; depends on nothing else.
`default_nettype none

package khddm_pkg;

  localparam int STAMP_BITS = 32;

  localparam logic [1:0] OP_KEY  = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_EVAL = 2'd2;

  localparam logic [3:0] KEY_UP       = 4'd0;
  localparam logic [3:0] KEY_DOWN     = 4'd1;
  localparam logic [3:0] KEY_LEFT     = 4'd2;
  localparam logic [3:0] KEY_RIGHT    = 4'd3;
  localparam logic [3:0] KEY_STOP     = 4'd4;
  localparam logic [3:0] KEY_SPEED_UP = 4'd5;
  localparam logic [3:0] KEY_SPEED_DN = 4'd6;
  localparam logic [3:0] KEY_DIGIT    = 4'd7;
  localparam logic [3:0] KEY_LTRIM_UP = 4'd8;
  localparam logic [3:0] KEY_LTRIM_DN = 4'd9;
  localparam logic [3:0] KEY_RTRIM_UP = 4'd10;
  localparam logic [3:0] KEY_RTRIM_DN = 4'd11;

  localparam int DIR_UP    = 0;
  localparam int DIR_DOWN  = 1;
  localparam int DIR_LEFT  = 2;
  localparam int DIR_RIGHT = 3;

  localparam logic [15:0] TIMEOUT_RESET = 16'd550;
  localparam logic [6:0]  SPEED_RESET   = 7'd45;
  localparam logic [6:0]  SPEED_STEP    = 7'd9;
  localparam logic [6:0]  SPEED_MIN     = 7'd9;
  localparam logic [6:0]  SPEED_MAX     = 7'd90;
  localparam logic [6:0]  SPEED_LOW_CAP = 7'd18;
  localparam logic [3:0]  LEVEL_MIN     = 4'd1;
  localparam logic [3:0]  LEVEL_MAX     = 4'd9;
  localparam logic [3:0]  TRIM_RESET    = 4'd10;
  localparam logic [3:0]  TRIM_MIN      = 4'd5;
  localparam logic [3:0]  TRIM_MAX      = 4'd15;

  // Rounded division by 18 and 30 as exact reciprocal multiplies on 12-bit numerators.
  localparam logic [11:0] BASE_BIAS   = 12'd18;
  localparam logic [12:0] BASE_RECIP  = 13'd3641;
  localparam int          BASE_SHIFT  = 17;
  localparam logic [11:0] CURVE_BIAS  = 12'd30;
  localparam logic [12:0] CURVE_RECIP = 13'd4370;
  localparam int          CURVE_SHIFT = 18;

  localparam logic [2:0] REG_TIMEOUT = 3'd0;

  typedef struct packed {
    logic [3:0] held;
    logic       up_older;
    logic       left_older;
  } hold_t;

endpackage

`default_nettype wire

@@ design/khddm_state.sv @@
// Key-hold state: time base, press stamps, speed and trims, with held-key decode.
// Depends on khddm_pkg.
`default_nettype none

module khddm_state import khddm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  wire logic [1:0]        op,
  input  wire logic [3:0]        key,
  input  wire logic [3:0]        level,
  input  wire logic [15:0]       timeout,
  output hold_t                  hold,
  output logic      [10:0]       prod_l,
  output logic      [10:0]       prod_r,
  output logic      [3:0]        trim_l,
  output logic      [3:0]        trim_r
);

  logic [STAMP_BITS-1:0] time_now, time_now_next;
  logic [STAMP_BITS-1:0] stamp [4];
  logic [STAMP_BITS-1:0] stamp_next [4];
  logic [STAMP_BITS-1:0] age [4];
  logic [3:0]            valid, valid_next;
  logic [6:0]            speed, speed_next;
  logic [3:0]            trim_l_next, trim_r_next;
  logic [3:0]            lvl;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      age[k] = time_now - stamp[k];
      hold.held[k] = valid[k] && (age[k][STAMP_BITS-1:16] == '0) && (age[k][15:0] < timeout);
    end
    hold.up_older   = age[DIR_UP] > age[DIR_DOWN];
    hold.left_older = age[DIR_LEFT] > age[DIR_RIGHT];
  end

  always_comb begin
    time_now_next = time_now;
    valid_next    = valid;
    speed_next    = speed;
    trim_l_next   = trim_l;
    trim_r_next   = trim_r;
    for (int k = 0; k < 4; k++) begin
      stamp_next[k] = stamp[k];
    end
    lvl = level;
    if (level < LEVEL_MIN) begin
      lvl = LEVEL_MIN;
    end else if (level > LEVEL_MAX) begin
      lvl = LEVEL_MAX;
    end
    if (fire) begin
      case (op)
        OP_KEY: begin
          case (key)
            KEY_UP: begin
              stamp_next[DIR_UP] = time_now;
              valid_next[DIR_UP] = 1'b1;
            end
            KEY_DOWN: begin
              stamp_next[DIR_DOWN] = time_now;
              valid_next[DIR_DOWN] = 1'b1;
            end
            KEY_LEFT: begin
              stamp_next[DIR_LEFT] = time_now;
              valid_next[DIR_LEFT] = 1'b1;
            end
            KEY_RIGHT: begin
              stamp_next[DIR_RIGHT] = time_now;
              valid_next[DIR_RIGHT] = 1'b1;
            end
            KEY_STOP: begin
              valid_next = '0;
            end
            KEY_SPEED_UP: begin
              speed_next = (speed + SPEED_STEP > SPEED_MAX) ? SPEED_MAX : speed + SPEED_STEP;
            end
            KEY_SPEED_DN: begin
              speed_next = (speed < SPEED_LOW_CAP) ? SPEED_MIN : speed - SPEED_STEP;
            end
            KEY_DIGIT: begin
              speed_next = {lvl, 3'b000} + {2'b00, lvl, 1'b0};
            end
            KEY_LTRIM_UP: begin
              trim_l_next = (trim_l < TRIM_MAX) ? trim_l + 4'd1 : TRIM_MAX;
            end
            KEY_LTRIM_DN: begin
              trim_l_next = (trim_l > TRIM_MIN) ? trim_l - 4'd1 : TRIM_MIN;
            end
            KEY_RTRIM_UP: begin
              trim_r_next = (trim_r < TRIM_MAX) ? trim_r + 4'd1 : TRIM_MAX;
            end
            KEY_RTRIM_DN: begin
              trim_r_next = (trim_r > TRIM_MIN) ? trim_r - 4'd1 : TRIM_MIN;
            end
            default: begin
            end
          endcase
        end
        OP_TICK: begin
          time_now_next = time_now + 1'b1;
          // A held stamp never ages past 65535, so reaching it means the next age is 65536.
          for (int k = 0; k < 4; k++) begin
            if (valid[k] && ((age[k][STAMP_BITS-1:16] != '0) || (age[k][15:0] == 16'hFFFF))) begin
              valid_next[k] = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_now <= '0;
      valid    <= '0;
      speed    <= SPEED_RESET;
      trim_l   <= TRIM_RESET;
      trim_r   <= TRIM_RESET;
      prod_l   <= 11'(SPEED_RESET * TRIM_RESET);
      prod_r   <= 11'(SPEED_RESET * TRIM_RESET);
      for (int k = 0; k < 4; k++) begin
        stamp[k] <= '0;
      end
    end else begin
      time_now <= time_now_next;
      valid    <= valid_next;
      speed    <= speed_next;
      trim_l   <= trim_l_next;
      trim_r   <= trim_r_next;
      prod_l   <= 11'(speed_next) * 11'(trim_l_next);
      prod_r   <= 11'(speed_next) * 11'(trim_r_next);
      for (int k = 0; k < 4; k++) begin
        stamp[k] <= stamp_next[k];
      end
    end
  end

endmodule

`default_nettype wire

@@ design/khddm_mix.sv @@
// Drive mixer: resolves direction conflicts and forms rounded left/right commands.
// Depends on khddm_pkg.
`default_nettype none

module khddm_mix import khddm_pkg::*; (
  input  hold_t              hold,
  input  wire logic [10:0]   prod_l,
  input  wire logic [10:0]   prod_r,
  input  wire logic [3:0]    trim_l,
  input  wire logic [3:0]    trim_r,
  output logic signed [7:0]  left_mix,
  output logic signed [7:0]  right_mix
);

  logic        fwd, back, turn_l, turn_r;
  logic [11:0] nb_l, nb_r, nc_l, nc_r;
  logic [24:0] pb_l, pb_r, pc_l, pc_r;
  logic [6:0]  base_l, base_r, curve_l, curve_r, spin_l, spin_r;
  logic [6:0]  mag_l, mag_r;
  logic        neg_l, neg_r;

  assign fwd    = hold.held[DIR_UP] && (!hold.held[DIR_DOWN] || hold.up_older);
  assign back   = hold.held[DIR_DOWN] && (!hold.held[DIR_UP] || !hold.up_older);
  assign turn_l = hold.held[DIR_LEFT] && (!hold.held[DIR_RIGHT] || hold.left_older);
  assign turn_r = hold.held[DIR_RIGHT] && (!hold.held[DIR_LEFT] || !hold.left_older);

  assign nb_l = {prod_l, 1'b0} + BASE_BIAS;
  assign nb_r = {prod_r, 1'b0} + BASE_BIAS;
  assign nc_l = {prod_l, 1'b0} + CURVE_BIAS;
  assign nc_r = {prod_r, 1'b0} + CURVE_BIAS;

  assign pb_l = 25'(nb_l) * 25'(BASE_RECIP);
  assign pb_r = 25'(nb_r) * 25'(BASE_RECIP);
  assign pc_l = 25'(nc_l) * 25'(CURVE_RECIP);
  assign pc_r = 25'(nc_r) * 25'(CURVE_RECIP);

  assign base_l  = pb_l[BASE_SHIFT +: 7];
  assign base_r  = pb_r[BASE_SHIFT +: 7];
  assign curve_l = pc_l[CURVE_SHIFT +: 7];
  assign curve_r = pc_r[CURVE_SHIFT +: 7];
  assign spin_l  = {1'b0, trim_l, 2'b00};
  assign spin_r  = {1'b0, trim_r, 2'b00};

  always_comb begin
    mag_l = '0;
    mag_r = '0;
    neg_l = 1'b0;
    neg_r = 1'b0;
    if (fwd || back) begin
      neg_l = back;
      neg_r = back;
      if (turn_l) begin
        mag_l = curve_l;
        mag_r = base_r;
      end else if (turn_r) begin
        mag_l = base_l;
        mag_r = curve_r;
      end else begin
        mag_l = base_l;
        mag_r = base_r;
      end
    end else if (turn_l) begin
      mag_l = spin_l;
      mag_r = spin_r;
      neg_l = 1'b1;
    end else if (turn_r) begin
      mag_l = spin_l;
      mag_r = spin_r;
      neg_r = 1'b1;
    end
  end

  // Magnitudes never exceed 75, so the commands stay inside the plus or minus 100 range.
  assign left_mix  = neg_l ? 8'd0 - {1'b0, mag_l} : {1'b0, mag_l};
  assign right_mix = neg_r ? 8'd0 - {1'b0, mag_r} : {1'b0, mag_r};

endmodule

`default_nettype wire

@@ design/key_hold_differential_drive_mixer.sv @@
// Key-hold differential drive mixer, top level: input register, state, mixer, result register.
// An evaluate beat waits in the input register; its result beat is registered as it fires from there.
// Throughput: one beat per cycle of any kind; an evaluate waits only while a result is stalled.
// Reset (rst, synchronous): no holds, time zero, speed 45, trims 10, timeout 550, no result.
// Depends on khddm_pkg, khddm_state and khddm_mix.
`default_nettype none

module key_hold_differential_drive_mixer import khddm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire logic [1:0]        operation,
  input  wire logic [3:0]        key_class,
  input  wire logic [3:0]        speed_level,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output logic signed [7:0]      left_drive,
  output logic signed [7:0]      right_drive,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  logic        stage_valid;
  logic [1:0]  stage_op;
  logic [3:0]  stage_key;
  logic [3:0]  stage_level;
  logic        out_free;
  logic        fire;
  logic        accept;
  logic [15:0] timeout;
  hold_t       hold;
  logic [10:0] prod_l, prod_r;
  logic [3:0]  trim_l, trim_r;
  logic signed [7:0] left_mix, right_mix;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_TIMEOUT) ? {16'd0, timeout} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_TIMEOUT[2])) begin
      timeout <= pwdata[15:0];
    end
  end

  assign out_free   = !result_valid || !result_stall;
  assign fire       = stage_valid && ((stage_op != OP_EVAL) || out_free);
  assign item_stall = stage_valid && !fire;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (fire) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_op    <= operation;
      stage_key   <= key_class;
      stage_level <= speed_level;
    end
  end

  khddm_state u_state (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .op      (stage_op),
    .key     (stage_key),
    .level   (stage_level),
    .timeout (timeout),
    .hold    (hold),
    .prod_l  (prod_l),
    .prod_r  (prod_r),
    .trim_l  (trim_l),
    .trim_r  (trim_r)
  );

  khddm_mix u_mix (
    .hold      (hold),
    .prod_l    (prod_l),
    .prod_r    (prod_r),
    .trim_l    (trim_l),
    .trim_r    (trim_r),
    .left_mix  (left_mix),
    .right_mix (right_mix)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire && (stage_op == OP_EVAL)) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && (stage_op == OP_EVAL)) begin
      left_drive  <= left_mix;
      right_drive <= right_mix;
    end
  end

endmodule

`default_nettype wire

@@ design/khddm_checker.sv @@
// Port-level checker for the key-hold differential drive mixer, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module khddm_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              item_stall,
  input wire logic              result_valid,
  input wire logic              result_stall,
  input wire logic signed [7:0] left_drive,
  input wire logic signed [7:0] right_drive
);

  // The input side only backs up behind a stalled result beat.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (result_valid && result_stall))
    else $error("input stalled without a stalled result beat");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!result_valid && !item_stall))
    else $error("result or stall active right after reset");

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((left_drive <= 8'sd100) && (left_drive >= -8'sd100) &&
                      (right_drive <= 8'sd100) && (right_drive >= -8'sd100)))
    else $error("drive command outside the plus or minus 100 range");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=>
      (result_valid && $stable(left_drive) && $stable(right_drive)))
    else $error("stalled result beat changed");

endmodule

bind key_hold_differential_drive_mixer khddm_checker u_khddm_checker (.*);

`default_nettype wire
